[rtl/sine_cosine_microstep_drive_defines.svh]
// Assertion macros for the microstep drive checker.
`ifndef SINE_COSINE_MICROSTEP_DRIVE_DEFINES_SVH
`define SINE_COSINE_MICROSTEP_DRIVE_DEFINES_SVH

// Checked only while the block is out of reset.
`define SCMD_ASSERT(lbl, prop, msg) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) prop) else $error(msg);

// Checked at every edge, reset included.
`define SCMD_ASSERT_ALWAYS(lbl, prop, msg) \
    lbl: assert property (@(posedge aclk) prop) else $error(msg);

`endif

[rtl/scmd_pkg.sv]
// Types, constants and the quarter-wave sine table of the microstep drive.
package scmd_pkg;

    localparam int ANGLE_BITS       = 16;
    localparam int LEVEL_BITS       = 10;
    localparam int LEVEL_MAX        = 1023;
    localparam int SINE_TABLE_DEPTH = 256;
    localparam int IDX_BITS         = $clog2(SINE_TABLE_DEPTH);
    localparam int ADDR_BITS        = IDX_BITS + 1;
    localparam int REM_BITS         = ANGLE_BITS - 2;
    localparam int TDATA_IN_BITS    = 16;
    localparam int TDATA_OUT_BITS   = 40;

    localparam longint unsigned Q30_ONE = 64'd1073741824;
    localparam longint unsigned PI_Q30  = 64'd3373259426;

    typedef logic [LEVEL_BITS-1:0] level_t;
    typedef logic [ADDR_BITS-1:0]  addr_t;

    localparam level_t LEVEL_FULL = level_t'(LEVEL_MAX);
    localparam addr_t  DEPTH_ADDR = addr_t'(SINE_TABLE_DEPTH);

    typedef enum logic [1:0] {
        QUAD_FIRST  = 2'd0,
        QUAD_SECOND = 2'd1,
        QUAD_THIRD  = 2'd2,
        QUAD_FOURTH = 2'd3
    } quadrant_t;

    localparam logic ACTION_DRIVE   = 1'b0;
    localparam logic ACTION_DISABLE = 1'b1;

    // One phase as handed to the H-bridge level mapper.
    typedef struct packed {
        logic   positive;
        level_t mag;
    } phase_t;

    typedef level_t qw_table_t [SINE_TABLE_DEPTH+1];

    // Restoring division, evaluated only while the table is built at elaboration.
    function automatic longint unsigned div_u64(longint unsigned num, longint unsigned den);
        longint unsigned quo;
        longint unsigned rmd;
        quo = '0;
        rmd = '0;
        for (int b = 63; b >= 0; b--) begin
            rmd = {rmd[62:0], num[b]};
            if (rmd >= den) begin
                rmd    = rmd - den;
                quo[b] = 1'b1;
            end
        end
        return quo;
    endfunction

    // Entry i holds LEVEL_MAX * sin(i * pi / (2 * depth)), truncated, with the
    // sine taken from a Q30 Taylor series that stops at its first zero term.
    function automatic level_t qw_entry(int unsigned i);
        longint unsigned x;
        longint unsigned x2;
        longint unsigned term;
        longint          sum;
        longint unsigned prod;
        logic            done;
        x    = (PI_Q30 * 64'(i)) >> (IDX_BITS + 1);
        x2   = (x * x) >> 30;
        term = x;
        sum  = longint'(x);
        done = 1'b0;
        for (int k = 1; k < 40; k++) begin
            if (!done) begin
                term = (term * x2) >> 30;
                term = div_u64(term, 64'(2 * k) * 64'(2 * k + 1));
                if (term == 64'd0) begin
                    done = 1'b1;
                end else if (k % 2 == 1) begin
                    sum = sum - longint'(term);
                end else begin
                    sum = sum + longint'(term);
                end
            end
        end
        if (sum < 0) begin
            sum = 0;
        end
        if (longint'(Q30_ONE) < sum) begin
            sum = longint'(Q30_ONE);
        end
        prod = (64'(LEVEL_MAX) * longint'(unsigned'(sum))) >> 30;
        return level_t'(prod);
    endfunction

    function automatic qw_table_t build_qw();
        qw_table_t t;
        for (int i = 0; i < SINE_TABLE_DEPTH; i++) begin
            t[i] = qw_entry(i);
        end
        t[SINE_TABLE_DEPTH] = LEVEL_FULL;
        return t;
    endfunction

    localparam qw_table_t QUARTER_WAVE = build_qw();

endpackage

[rtl/scmd_phase_map.sv]
// Maps one signed phase onto the duty levels of its H-bridge legs.
module scmd_phase_map (
    input  scmd_pkg::phase_t phase,
    input  logic             inverted,
    output scmd_pkg::level_t level_pos,
    output scmd_pkg::level_t level_neg
);

    scmd_pkg::level_t rest;

    assign rest = scmd_pkg::LEVEL_FULL - phase.mag;

    always_comb begin
        if (inverted) begin
            // The idle leg sits at full level and the driven leg drops below it.
            if (phase.positive) begin
                level_pos = rest;
                level_neg = scmd_pkg::LEVEL_FULL;
            end else begin
                level_pos = scmd_pkg::LEVEL_FULL;
                level_neg = rest;
            end
        end else begin
            if (phase.positive) begin
                level_pos = phase.mag;
                level_neg = '0;
            end else begin
                level_pos = '0;
                level_neg = phase.mag;
            end
        end
    end

endmodule

[rtl/sine_cosine_microstep_drive.sv]
// An accepted request reaches its result through one input and one output register.
// Throughput: one request per cycle unless the output stalls; table lookup and level mapping fit between registers.
// A stalled output holds its result while one more request waits in the input register.
// Reset (aresetn low, synchronous) empties both stages and selects normal level mapping.
// The configuration channel is always ready.
module sine_cosine_microstep_drive (
    input  logic                                 aclk,
    input  logic                                 aresetn,
    input  logic                                 cfg_valid,
    output logic                                 cfg_ready,
    input  logic                                 cfg_data,   // decay_inverted
    input  logic                                 s_tvalid,
    output logic                                 s_tready,
    input  logic [scmd_pkg::TDATA_IN_BITS-1:0]   s_tdata,    // angle
    input  logic                                 s_tuser,    // action
    output logic                                 m_tvalid,
    input  logic                                 m_tready,
    output logic [scmd_pkg::TDATA_OUT_BITS-1:0]  m_tdata     // level_a_pos, level_a_neg,
                                                             // level_b_pos, level_b_neg
);

    logic                                inverted_reg;
    logic                                in_valid_reg;
    logic                                action_reg;
    logic [scmd_pkg::ANGLE_BITS-1:0]     angle_reg;
    logic                                out_valid_reg;
    logic [scmd_pkg::TDATA_OUT_BITS-1:0] out_data_reg;
    logic [scmd_pkg::TDATA_OUT_BITS-1:0] out_data_next;

    logic                                out_advance;
    logic                                in_advance;

    scmd_pkg::quadrant_t                 quad;
    logic [scmd_pkg::REM_BITS-1:0]       rem;
    scmd_pkg::addr_t                     addr_lo;
    scmd_pkg::addr_t                     addr_hi;
    scmd_pkg::level_t                    mag_lo;
    scmd_pkg::level_t                    mag_hi;
    scmd_pkg::phase_t                    phase_a;
    scmd_pkg::phase_t                    phase_b;
    scmd_pkg::level_t                    a_pos;
    scmd_pkg::level_t                    a_neg;
    scmd_pkg::level_t                    b_pos;
    scmd_pkg::level_t                    b_neg;

    assign cfg_ready   = 1'b1;
    assign out_advance = !out_valid_reg || m_tready;
    assign in_advance  = !in_valid_reg || out_advance;
    assign s_tready    = in_advance;
    assign m_tvalid    = out_valid_reg;
    assign m_tdata     = out_data_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            inverted_reg <= 1'b0;
        end else if (cfg_valid && cfg_ready) begin
            inverted_reg <= cfg_data;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end else begin
            if (in_advance) begin
                in_valid_reg <= s_tvalid;
            end
            if (out_advance) begin
                out_valid_reg <= in_valid_reg;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (in_advance && s_tvalid) begin
            action_reg <= s_tuser;
            angle_reg  <= s_tdata[scmd_pkg::ANGLE_BITS-1:0];
        end
        if (out_advance && in_valid_reg) begin
            out_data_reg <= out_data_next;
        end
    end

    // Fold the angle into one quarter wave; the table index is the top bits of the remainder.
    assign quad    = scmd_pkg::quadrant_t'(angle_reg[scmd_pkg::ANGLE_BITS-1 -: 2]);
    assign rem     = angle_reg[scmd_pkg::REM_BITS-1:0];
    assign addr_lo = {1'b0, rem[scmd_pkg::REM_BITS-1 -: scmd_pkg::IDX_BITS]};
    assign addr_hi = scmd_pkg::DEPTH_ADDR - addr_lo;
    assign mag_lo  = scmd_pkg::QUARTER_WAVE[addr_lo];
    assign mag_hi  = scmd_pkg::QUARTER_WAVE[addr_hi];

    always_comb begin
        case (quad)
            scmd_pkg::QUAD_FIRST: begin
                phase_a = '{positive: (mag_lo != '0), mag: mag_lo};
                phase_b = '{positive: (mag_hi != '0), mag: mag_hi};
            end
            scmd_pkg::QUAD_SECOND: begin
                phase_a = '{positive: (mag_hi != '0), mag: mag_hi};
                phase_b = '{positive: 1'b0, mag: mag_lo};
            end
            scmd_pkg::QUAD_THIRD: begin
                phase_a = '{positive: 1'b0, mag: mag_lo};
                phase_b = '{positive: 1'b0, mag: mag_hi};
            end
            scmd_pkg::QUAD_FOURTH: begin
                phase_a = '{positive: 1'b0, mag: mag_hi};
                phase_b = '{positive: (mag_lo != '0), mag: mag_lo};
            end
            default: begin
                phase_a = '{positive: 1'b0, mag: '0};
                phase_b = '{positive: 1'b0, mag: '0};
            end
        endcase
    end

    scmd_phase_map u_map_a (
        .phase     (phase_a),
        .inverted  (inverted_reg),
        .level_pos (a_pos),
        .level_neg (a_neg)
    );

    scmd_phase_map u_map_b (
        .phase     (phase_b),
        .inverted  (inverted_reg),
        .level_pos (b_pos),
        .level_neg (b_neg)
    );

    always_comb begin
        if (action_reg == scmd_pkg::ACTION_DISABLE) begin
            out_data_next = '0;
        end else begin
            out_data_next = {b_neg, b_pos, a_neg, a_pos};
        end
    end

endmodule

[rtl/scmd_checker.sv]
// Port-level checker for the microstep drive, bound to the top level.
`include "sine_cosine_microstep_drive_defines.svh"

module scmd_checker (
    input logic                                aclk,
    input logic                                aresetn,
    input logic                                s_tvalid,
    input logic                                s_tready,
    input logic                                m_tvalid,
    input logic                                m_tready,
    input logic [scmd_pkg::TDATA_OUT_BITS-1:0] m_tdata
);

    scmd_pkg::level_t a_pos;
    scmd_pkg::level_t a_neg;
    scmd_pkg::level_t b_pos;
    scmd_pkg::level_t b_neg;

    assign a_pos = m_tdata[9:0];
    assign a_neg = m_tdata[19:10];
    assign b_pos = m_tdata[29:20];
    assign b_neg = m_tdata[39:30];

    `SCMD_ASSERT(a_out_hold, (m_tvalid && !m_tready) |=> (m_tvalid && $stable(m_tdata)), "result changed while stalled")
    `SCMD_ASSERT_ALWAYS(a_reset_empty, (!aresetn) |=> (!m_tvalid), "result shown right after reset")
    `SCMD_ASSERT(a_latency, (s_tvalid && s_tready) |=> ##1 m_tvalid, "request gave no result after two cycles")
    `SCMD_ASSERT(a_stall_cause, (!s_tready) |-> (m_tvalid && !m_tready), "input stalled without a stalled result")
    `SCMD_ASSERT(a_leg_pair, m_tvalid |-> ((a_pos == '0 || a_neg == '0 || a_pos == scmd_pkg::LEVEL_FULL || a_neg == scmd_pkg::LEVEL_FULL) && (b_pos == '0 || b_neg == '0 || b_pos == scmd_pkg::LEVEL_FULL || b_neg == scmd_pkg::LEVEL_FULL)), "both legs of a phase driven partially")

endmodule

bind sine_cosine_microstep_drive scmd_checker u_scmd_checker (
    .aclk     (aclk),
    .aresetn  (aresetn),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata)
);
